// File: design/assert_macros.svh
// assertion macros shared by the sccb register master
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/scm_pkg.sv
// types, codes and helpers for the sccb register master
package scm_pkg;

	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic [7:0] DEV_ADDR_RESET = 8'd66;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_WRITE,
		CMD_READ
	} cmd_t;

	typedef enum logic [4:0] {
		PH_IDLE      = 5'd0,
		PH_START_A   = 5'd1,
		PH_START_B   = 5'd2,
		PH_SEND_DEV  = 5'd3,
		PH_ACK_DEV   = 5'd4,
		PH_SEND_REG  = 5'd5,
		PH_ACK_REG   = 5'd6,
		PH_SEND_DATA = 5'd7,
		PH_ACK_DATA  = 5'd8,
		PH_STOP_MID  = 5'd9,
		PH_START2_A  = 5'd10,
		PH_START2_B  = 5'd11,
		PH_SEND_RDEV = 5'd12,
		PH_ACK_RDEV  = 5'd13,
		PH_RECV      = 5'd14,
		PH_MACK      = 5'd15,
		PH_STOP_OK   = 5'd16,
		PH_STOP_FAIL = 5'd17
	} phase_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] sub_addr;
		logic [7:0] wr_data;
		logic [7:0] read_len;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_oe;
		logic       busy_res;
		logic       done_res;
		logic       ok;
		logic [7:0] rd_data;
		logic       rd_valid;
		logic       rd_last;
	} out_item_t;

	// classified request as it sits in the queue
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] sub_addr;
		logic [7:0] wr_data;
		logic [7:0] read_len;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic head_valid;
		logic full;
	} q_stat_t;

	// ack phase that follows each byte send phase
	function automatic phase_t ack_of(input phase_t ph);
		phase_t r;
		case (ph)
			PH_SEND_DEV:  r = PH_ACK_DEV;
			PH_SEND_REG:  r = PH_ACK_REG;
			PH_SEND_DATA: r = PH_ACK_DATA;
			PH_SEND_RDEV: r = PH_ACK_RDEV;
			default:      r = PH_IDLE;
		endcase
		return r;
	endfunction

endpackage

// File: design/sccb_register_master.sv
// top level of the sccb register master: front end, queue and bus engine
//
//   channel | signals                        | direction
//   in      | in_valid, in_stall, in_item    | request in, one bus tick each
//   out     | out_valid, out_stall, out_item | one result per tick
//   cfg     | cfg_we, cfg_wdata              | device address write
//
// one tick per clock is sustained while the output is not stalled; a request taken is first written
// into a queue slot, and the engine then loads its result into the result register that drives out_valid
// the engine sequencer and the device address register carry state from tick to tick
// reset clears the queue, the sequencer and the result valid flag at once, and restores the device address
// a stalled output holds the engine; the queue then fills and stalls the input
`include "assert_macros.svh"

module sccb_register_master
	import scm_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	req_t    req;
	req_t    head;

	scm_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_stat   (q_stat),
		.push     (push),
		.req      (req)
	);

	scm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (req),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	scm_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// a received byte never coincides with completion
	`ASSERT_IMPLY(a_rd_not_done, clk, arst_n, out_valid && out_item.rd_valid, !out_item.done_res && out_item.busy_res && !out_item.sda_oe, "read byte reported with done or while driving sda")
	// success only reported with done
	`ASSERT_IMPLY(a_ok_with_done, clk, arst_n, out_valid && out_item.ok, out_item.done_res, "ok without done")
	// the engine only pops a queued request
	`ASSERT_IMPLY(a_pop_valid, clk, arst_n, pop, q_stat.head_valid, "pop from empty queue")
	// a full queue that is not popped stays full, as its stalled input pushes nothing
	`ASSERT_NEXT(a_full_holds, clk, arst_n, q_stat.full && !pop, q_stat.full, "full queue lost an entry")

endmodule

// File: design/scm_front.sv
// front end: takes requests and classifies the command code
module scm_front
	import scm_pkg::*;
(
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_item,
	input  q_stat_t  q_stat,
	output logic     push,
	output req_t     req
);

	cmd_t cmd;

	always_comb begin
		case (in_item.func)
			FUNC_WRITE: cmd = CMD_WRITE;
			FUNC_READ:  cmd = CMD_READ;
			FUNC_TICK:  cmd = CMD_TICK;
			default:    cmd = CMD_TICK;
		endcase
	end

	assign in_stall     = q_stat.full;
	assign push         = in_valid && !q_stat.full;
	assign req.cmd      = cmd;
	assign req.sub_addr = in_item.sub_addr;
	assign req.wr_data  = in_item.wr_data;
	assign req.read_len = in_item.read_len;
	assign req.sda_in   = in_item.sda_in;

endmodule

// File: design/scm_queue.sv
// short request queue between the front end and the bus engine
module scm_queue
	import scm_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  req_t    push_req,
	input  logic    pop,
	output req_t    head,
	output q_stat_t q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	req_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	assign head              = mem_q[rd_ptr_q];
	assign q_stat.head_valid = (count_q != '0);
	assign q_stat.full       = (count_q == CNT_W'(DEPTH));

endmodule

// File: design/scm_engine.sv
// back end: sccb bit sequencer with the result register
module scm_engine
	import scm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [7:0] cfg_wdata,
	input  req_t      head,
	input  q_stat_t   q_stat,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	logic [7:0] dev_addr_q;
	phase_t     phase_q, phase_d, eff_phase;
	logic       sub_q, sub_d;
	logic [2:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] left_q, left_d;
	logic [7:0] reg_q, reg_d;
	logic [7:0] data_q, data_d;
	logic       is_read_q, is_read_d;
	logic       start_cmd;
	logic       sda;
	logic       adv;
	out_item_t  res;
	logic       out_valid_q;
	out_item_t  out_item_q;

	assign sda       = head.sda_in;
	assign start_cmd = (phase_q == PH_IDLE) && (head.cmd inside {CMD_WRITE, CMD_READ});
	assign eff_phase = start_cmd ? PH_START_A : phase_q;
	assign adv       = q_stat.head_valid && (!out_valid_q || !out_stall);
	assign pop       = adv;

	always_comb begin : next_state
		phase_d   = phase_q;
		sub_d     = sub_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		left_d    = left_q;
		reg_d     = reg_q;
		data_d    = data_q;
		is_read_d = is_read_q;
		if (start_cmd) begin
			reg_d     = head.sub_addr;
			data_d    = head.wr_data;
			left_d    = head.read_len;
			is_read_d = (head.cmd == CMD_READ);
			sub_d     = 1'b0;
			bit_d     = '0;
		end
		case (eff_phase)
			PH_IDLE: begin
			end
			PH_START_A, PH_START2_A: begin
				if (!sda) begin
					phase_d = PH_IDLE;
				end else begin
					phase_d = (eff_phase == PH_START_A) ? PH_START_B : PH_START2_B;
				end
			end
			PH_START_B, PH_START2_B: begin
				if (sda) begin
					phase_d = PH_IDLE;
				end else begin
					phase_d = (eff_phase == PH_START_B) ? PH_SEND_DEV : PH_SEND_RDEV;
					shift_d = (eff_phase == PH_START_B) ? dev_addr_q : dev_addr_q + 8'd1;
					bit_d   = '0;
					sub_d   = 1'b0;
				end
			end
			PH_SEND_DEV, PH_SEND_REG, PH_SEND_DATA, PH_SEND_RDEV: begin
				sub_d = !sub_q;
				if (sub_q) begin
					shift_d = {shift_q[6:0], 1'b0};
					bit_d   = bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						phase_d = ack_of(eff_phase);
					end
				end
			end
			PH_ACK_DEV, PH_ACK_REG, PH_ACK_DATA, PH_ACK_RDEV: begin
				sub_d = !sub_q;
				if (sub_q) begin
					case (eff_phase)
						PH_ACK_DEV: begin
							if (sda) begin
								phase_d = PH_STOP_FAIL;
							end else begin
								phase_d = PH_SEND_REG;
								shift_d = reg_q;
								bit_d   = '0;
							end
						end
						PH_ACK_REG: begin
							if (is_read_q) begin
								phase_d = PH_STOP_MID;
							end else begin
								phase_d = PH_SEND_DATA;
								shift_d = data_q;
								bit_d   = '0;
							end
						end
						PH_ACK_DATA: begin
							phase_d = PH_STOP_OK;
						end
						default: begin
							if (sda) begin
								phase_d = PH_STOP_FAIL;
							end else if (left_q == 8'd0) begin
								phase_d = PH_STOP_OK;
							end else begin
								phase_d = PH_RECV;
								shift_d = 8'd0;
								bit_d   = '0;
							end
						end
					endcase
				end
			end
			PH_RECV: begin
				sub_d = !sub_q;
				if (sub_q) begin
					shift_d = {shift_q[6:0], sda};
					bit_d   = bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						phase_d = PH_MACK;
					end
				end
			end
			PH_MACK: begin
				sub_d = !sub_q;
				if (sub_q) begin
					left_d = left_q - 8'd1;
					if (left_q == 8'd1) begin
						phase_d = PH_STOP_OK;
					end else begin
						phase_d = PH_RECV;
						shift_d = 8'd0;
						bit_d   = '0;
					end
				end
			end
			PH_STOP_MID, PH_STOP_OK, PH_STOP_FAIL: begin
				sub_d = !sub_q;
				if (sub_q) begin
					phase_d = (eff_phase == PH_STOP_MID) ? PH_START2_A : PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_comb begin : outputs
		res          = '0;
		res.scl      = 1'b1;
		res.sda_out  = 1'b1;
		res.sda_oe   = 1'b1;
		res.busy_res = 1'b1;
		case (eff_phase)
			PH_START_A, PH_START2_A: begin
				res.sda_oe   = 1'b0;
				res.done_res = !sda;
			end
			PH_START_B, PH_START2_B: begin
				res.sda_out  = 1'b0;
				res.done_res = sda;
			end
			PH_SEND_DEV, PH_SEND_REG, PH_SEND_DATA, PH_SEND_RDEV: begin
				res.scl     = sub_q;
				res.sda_out = shift_q[7];
			end
			PH_ACK_DEV, PH_ACK_REG, PH_ACK_DATA, PH_ACK_RDEV: begin
				res.scl    = sub_q;
				res.sda_oe = 1'b0;
			end
			PH_RECV: begin
				res.scl    = sub_q;
				res.sda_oe = 1'b0;
				// eighth bit sampled on this high tick
				if (sub_q && (bit_q == 3'd7)) begin
					res.rd_valid = 1'b1;
					res.rd_data  = {shift_q[6:0], sda};
					res.rd_last  = (left_q == 8'd1);
				end
			end
			PH_MACK: begin
				res.scl     = sub_q;
				res.sda_out = (left_q == 8'd1);
			end
			PH_STOP_MID, PH_STOP_OK, PH_STOP_FAIL: begin
				res.scl     = sub_q;
				res.sda_out = sub_q;
				if (sub_q && (eff_phase != PH_STOP_MID)) begin
					res.done_res = 1'b1;
					res.ok       = (eff_phase == PH_STOP_OK);
				end
			end
			default: begin
				res.busy_res = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q  <= DEV_ADDR_RESET;
			phase_q     <= PH_IDLE;
			sub_q       <= 1'b0;
			bit_q       <= '0;
			shift_q     <= '0;
			left_q      <= '0;
			reg_q       <= '0;
			data_q      <= '0;
			is_read_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				dev_addr_q <= cfg_wdata;
			end
			if (adv) begin
				phase_q   <= phase_d;
				sub_q     <= sub_d;
				bit_q     <= bit_d;
				shift_q   <= shift_d;
				left_q    <= left_d;
				reg_q     <= reg_d;
				data_q    <= data_d;
				is_read_q <= is_read_d;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
